### hdl/alr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the antialiased line rasterizer.
// Used by alr_ctrl, alr_datapath, the top level and the checker; no dependencies.
package alr_pkg;

  // Fixed widths of the port fields.
  localparam int POS_W   = 6;
  localparam int LEVEL_W = 8;
  localparam int SIDE_W  = 8;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [0:0] {
    OP_MOVE = 1'b0,
    OP_LINE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    CASE_VERT        = 3'd0,
    CASE_STEEP_POS   = 3'd1,
    CASE_SHALLOW_POS = 3'd2,
    CASE_SHALLOW_NEG = 3'd3,
    CASE_STEEP_NEG   = 3'd4
  } slope_case_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_LOAD,
    ST_PIXEL
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic pen_from_in;
    logic latch_tgt;
    logic setup;
    logic div_step;
    logic load_err;
    logic advance;
    logic pen_from_tgt;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic line_empty;
    logic vertical;
    logic div_last;
    logic pix_last;
  } sts_t;

endpackage

### hdl/alr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the line rasterizer: sequences setup, slope
// division and pixel stepping. Depends on alr_pkg.
module alr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          opcode_i,
  input  logic          out_stall_i,
  input  alr_pkg::sts_t sts_i,
  output alr_pkg::cmd_t cmd_o,
  output logic          in_stall_o,
  output logic          out_valid_o
);

  alr_pkg::state_e state_q, state_d;
  logic is_line;

  assign is_line = (opcode_i == 1'(alr_pkg::OP_LINE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      alr_pkg::ST_IDLE: begin
        if (in_valid_i && is_line) state_d = alr_pkg::ST_SETUP;
      end
      alr_pkg::ST_SETUP: begin
        if (sts_i.line_empty)    state_d = alr_pkg::ST_IDLE;
        else if (sts_i.vertical) state_d = alr_pkg::ST_PIXEL;
        else                     state_d = alr_pkg::ST_DIV;
      end
      alr_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = alr_pkg::ST_LOAD;
      end
      alr_pkg::ST_LOAD: begin
        state_d = alr_pkg::ST_PIXEL;
      end
      alr_pkg::ST_PIXEL: begin
        if (!out_stall_i && sts_i.pix_last) state_d = alr_pkg::ST_IDLE;
      end
      default: state_d = alr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      alr_pkg::ST_IDLE: begin
        in_stall_o        = 1'b0;
        cmd_o.pen_from_in = in_valid_i && !is_line;
        cmd_o.latch_tgt   = in_valid_i && is_line;
      end
      alr_pkg::ST_SETUP: begin
        cmd_o.setup        = 1'b1;
        cmd_o.pen_from_tgt = sts_i.line_empty;
      end
      alr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      alr_pkg::ST_LOAD: begin
        cmd_o.load_err = 1'b1;
      end
      alr_pkg::ST_PIXEL: begin
        out_valid_o        = 1'b1;
        cmd_o.advance      = !out_stall_i;
        cmd_o.pen_from_tgt = !out_stall_i && sts_i.pix_last;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

### hdl/alr_datapath.sv
`timescale 1ns / 1ps
// Datapath of the line rasterizer: pen, slope classification, bit-serial
// slope divider, error accumulator and pixel coordinates. Depends on alr_pkg.
module alr_datapath #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alr_pkg::cmd_t               cmd_i,
  output alr_pkg::sts_t               sts_o,
  input  logic [alr_pkg::POS_W-1:0]   pos_x_i,
  input  logic [alr_pkg::POS_W-1:0]   pos_y_i,
  output logic [alr_pkg::POS_W-1:0]   main_x_o,
  output logic [alr_pkg::POS_W-1:0]   main_y_o,
  output logic [alr_pkg::LEVEL_W-1:0] main_level_o,
  output logic [alr_pkg::SIDE_W-1:0]  side_x_o,
  output logic [alr_pkg::SIDE_W-1:0]  side_y_o,
  output logic [alr_pkg::LEVEL_W-1:0] side_level_o,
  output logic                        side_valid_o,
  output logic                        last_o
);

  localparam int CB     = COORD_BITS;
  localparam int FB     = FRAC_BITS;
  localparam int EW     = FB + 2;
  localparam int QW     = FB + 1;
  localparam int DCW    = $clog2(FB);
  localparam int PosW   = alr_pkg::POS_W;
  localparam int SideW  = alr_pkg::SIDE_W;
  localparam int LevelW = alr_pkg::LEVEL_W;
  localparam logic [EW-1:0] One = {2'b01, {FB{1'b0}}};
  localparam logic [DCW-1:0] DivLast = DCW'(FB - 1);

  logic [CB-1:0] pen_x_q, pen_y_q, tgt_x_q, tgt_y_q;
  logic [CB-1:0] cx_q, cy_q, n_q, pix_cnt_q, den_q, rem_q;
  logic [QW-1:0] quo_q, slope_q;
  logic [EW-1:0] err_q;
  logic [DCW-1:0] div_cnt_q;
  alr_pkg::slope_case_e case_q;

  // Setup signals
  logic signed [CB:0] dx, dy;
  logic [CB-1:0] adx, ady, start_x, start_y, n_d, num_d, den_d;
  logic dx_zero, dy_zero, pos_slope, shallow;
  alr_pkg::slope_case_e case_d;

  // Step signals
  logic [CB:0] rem_sh;
  logic rem_ge;
  logic [EW-1:0] err_sum, err_next;
  logic carry;
  logic [CB-1:0] cx_d, cy_d;
  logic vert;

  function automatic logic [LevelW-1:0] level_of(input logic [EW-1:0] e);
    logic [EW+7:0] p;
    logic [EW+7:0] s;
    p = {e, 8'd0} - {8'd0, e};
    s = p >> FB;
    level_of = (s > (EW+8)'(255)) ? LevelW'(255) : s[LevelW-1:0];
  endfunction

  // Classify the line from pen to target.
  always_comb begin
    dx      = $signed({1'b0, tgt_x_q}) - $signed({1'b0, pen_x_q});
    dy      = $signed({1'b0, tgt_y_q}) - $signed({1'b0, pen_y_q});
    adx     = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady     = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);
    pos_slope = dy_zero || (dx[CB] == dy[CB]);
    shallow   = (ady <= adx);
    start_x = pen_x_q;
    start_y = pen_y_q;
    n_d     = ady;
    num_d   = adx;
    den_d   = ady;
    if (dx_zero) begin
      case_d  = alr_pkg::CASE_VERT;
      start_y = (pen_y_q < tgt_y_q) ? pen_y_q : tgt_y_q;
    end else if (shallow) begin
      case_d = pos_slope ? alr_pkg::CASE_SHALLOW_POS : alr_pkg::CASE_SHALLOW_NEG;
      n_d    = adx;
      num_d  = ady;
      den_d  = adx;
      if (pen_x_q > tgt_x_q) begin
        start_x = tgt_x_q;
        start_y = tgt_y_q;
      end
    end else if (pos_slope) begin
      case_d = alr_pkg::CASE_STEEP_POS;
      if (pen_y_q > tgt_y_q) begin
        start_x = tgt_x_q;
        start_y = tgt_y_q;
      end
    end else begin
      case_d = alr_pkg::CASE_STEEP_NEG;
      if (pen_y_q < tgt_y_q) begin
        start_x = tgt_x_q;
        start_y = tgt_y_q;
      end
    end
  end

  // One quotient bit per cycle; remainder always below the divisor.
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  // Error accumulator and walk.
  always_comb begin
    err_sum  = err_q + {1'b0, slope_q};
    carry    = (err_sum >= One);
    err_next = carry ? (err_sum - One) : err_sum;
    cx_d     = cx_q;
    cy_d     = cy_q;
    case (case_q)
      alr_pkg::CASE_VERT: begin
        cy_d = cy_q + CB'(1);
      end
      alr_pkg::CASE_SHALLOW_POS: begin
        cx_d = cx_q + CB'(1);
        cy_d = cy_q + CB'(carry);
      end
      alr_pkg::CASE_SHALLOW_NEG: begin
        cx_d = cx_q + CB'(1);
        cy_d = cy_q - CB'(carry);
      end
      alr_pkg::CASE_STEEP_POS: begin
        cy_d = cy_q + CB'(1);
        cx_d = cx_q + CB'(carry);
      end
      alr_pkg::CASE_STEEP_NEG: begin
        cy_d = cy_q - CB'(1);
        cx_d = cx_q + CB'(carry);
      end
      default: begin
        cx_d = cx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      case_q  <= alr_pkg::CASE_VERT;
    end else begin
      if (cmd_i.pen_from_in) begin
        pen_x_q <= pos_x_i[CB-1:0];
        pen_y_q <= pos_y_i[CB-1:0];
      end else if (cmd_i.pen_from_tgt) begin
        pen_x_q <= tgt_x_q;
        pen_y_q <= tgt_y_q;
      end
      if (cmd_i.setup) case_q <= case_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_tgt) begin
      tgt_x_q <= pos_x_i[CB-1:0];
      tgt_y_q <= pos_y_i[CB-1:0];
    end
    if (cmd_i.setup) begin
      cx_q      <= start_x;
      cy_q      <= start_y;
      n_q       <= n_d;
      den_q     <= den_d;
      pix_cnt_q <= '0;
      div_cnt_q <= '0;
      err_q     <= '0;
      // Integer quotient bit is set only when numerator equals divisor.
      rem_q     <= (num_d == den_d) ? '0 : num_d;
      quo_q     <= QW'(num_d == den_d);
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? CB'(rem_sh - {1'b0, den_q}) : rem_sh[CB-1:0];
      quo_q     <= {quo_q[QW-2:0], rem_ge};
      div_cnt_q <= div_cnt_q + DCW'(1);
    end
    if (cmd_i.load_err) begin
      slope_q <= quo_q;
      err_q   <= {1'b0, quo_q};
    end
    if (cmd_i.advance) begin
      pix_cnt_q <= pix_cnt_q + CB'(1);
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      err_q     <= err_next;
    end
  end

  assign sts_o.line_empty = (n_d == '0);
  assign sts_o.vertical   = dx_zero;
  assign sts_o.div_last   = (div_cnt_q == DivLast);
  assign sts_o.pix_last   = (CB'(pix_cnt_q + CB'(1)) == n_q);

  assign vert = (case_q == alr_pkg::CASE_VERT);

  always_comb begin
    main_x_o     = PosW'(cx_q);
    main_y_o     = PosW'(cy_q);
    main_level_o = vert ? '0 : level_of(err_q);
    side_valid_o = !vert;
    last_o       = sts_o.pix_last;
    side_level_o = (vert || err_q >= One) ? '0 : level_of(One - err_q);
    side_x_o     = SideW'(cx_q);
    side_y_o     = SideW'(cy_q);
    case (case_q)
      alr_pkg::CASE_VERT: begin
        side_x_o = '0;
        side_y_o = '0;
      end
      alr_pkg::CASE_SHALLOW_POS: side_y_o = SideW'(cy_q) + SideW'(1);
      alr_pkg::CASE_SHALLOW_NEG: side_y_o = SideW'(cy_q) - SideW'(1);
      alr_pkg::CASE_STEEP_POS:   side_x_o = SideW'(cx_q) + SideW'(1);
      alr_pkg::CASE_STEEP_NEG:   side_x_o = SideW'(cx_q) + SideW'(1);
      default:                   side_x_o = SideW'(cx_q);
    endcase
  end

endmodule

### hdl/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps
// Antialiased line rasterizer, top level. A move transaction only updates the pen.
// A line transaction stalls the input through setup, slope divide and error load,
// then emits one pixel transaction per cycle while the output is not stalled, for
// |major axis| pixels; a vertical line skips the divide and load, a zero-length line
// emits no pixel. The slope divider is bit-serial and a single pixel stepper walks the line.
// Asynchronous active-low reset clears pen to (0,0) and returns to idle.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [alr_pkg::POS_W-1:0]   pos_x_i,
  input  logic [alr_pkg::POS_W-1:0]   pos_y_i,
  // Pixel channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [alr_pkg::POS_W-1:0]   main_x_o,
  output logic [alr_pkg::POS_W-1:0]   main_y_o,
  output logic [alr_pkg::LEVEL_W-1:0] main_level_o,
  output logic [alr_pkg::SIDE_W-1:0]  side_x_o,
  output logic [alr_pkg::SIDE_W-1:0]  side_y_o,
  output logic [alr_pkg::LEVEL_W-1:0] side_level_o,
  output logic                        side_valid_o,
  output logic                        last_o
);

  // Command and status between the sequencer and the datapath.
  alr_pkg::cmd_t cmd;
  alr_pkg::sts_t sts;

  // Sequencer: accepts commands only when idle, holds the pixel payload
  // steady while the downstream stalls.
  alr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Datapath: pen, slope divider, error accumulator, pixel walker. The
  // pixel payload comes straight from its registers, which change during
  // pixel output only when a pixel transaction completes.
  alr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .main_x_o     (main_x_o),
    .main_y_o     (main_y_o),
    .main_level_o (main_level_o),
    .side_x_o     (side_x_o),
    .side_y_o     (side_y_o),
    .side_level_o (side_level_o),
    .side_valid_o (side_valid_o),
    .last_o       (last_o)
  );

endmodule

### hdl/alr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the antialiased line rasterizer, bound to the top level.
// Depends on alr_pkg.
module alr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        opcode_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [alr_pkg::POS_W-1:0]   main_x_o,
  input logic [alr_pkg::POS_W-1:0]   main_y_o,
  input logic [alr_pkg::LEVEL_W-1:0] main_level_o,
  input logic                        side_valid_o,
  input logic                        last_o
);

  // A line transaction closes the command channel on the next cycle.
  a_line_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == 1'(alr_pkg::OP_LINE)) |=> in_stall_o)
    else $error("line command accepted without stalling input");

  // No command is taken while pixels are being emitted.
  a_busy_when_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while pixel pending");

  // Hold the pixel while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(main_x_o) && $stable(main_y_o) && $stable(last_o)))
    else $error("stalled pixel changed");

  // Vertical pixels carry level zero.
  a_vert_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !side_valid_o) |-> (main_level_o == '0))
    else $error("vertical pixel with nonzero level");

  // The last pixel of a line ends the pixel burst.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("pixels continue after last");

endmodule

bind antialiased_line_rasterizer alr_checker u_alr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .main_x_o     (main_x_o),
  .main_y_o     (main_y_o),
  .main_level_o (main_level_o),
  .side_valid_o (side_valid_o),
  .last_o       (last_o)
);

### tb/alr_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the antialiased line rasterizer: predicts the pixel stream of each
// accepted command and compares every accepted pixel against it. Depends on alr_pkg.
module alr_pixel_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [alr_pkg::POS_W-1:0]   pos_x_i,
  input  logic [alr_pkg::POS_W-1:0]   pos_y_i,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [alr_pkg::POS_W-1:0]   main_x_o,
  input  logic [alr_pkg::POS_W-1:0]   main_y_o,
  input  logic [alr_pkg::LEVEL_W-1:0] main_level_o,
  input  logic [alr_pkg::SIDE_W-1:0]  side_x_o,
  input  logic [alr_pkg::SIDE_W-1:0]  side_y_o,
  input  logic [alr_pkg::LEVEL_W-1:0] side_level_o,
  input  logic                        side_valid_o,
  input  logic                        last_o,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          commands_o,
  output logic [4:0]                  cases_seen_o
);

  localparam int FRAC = alr_pkg::FRAC_BITS_DEF;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC;

  typedef struct packed {
    logic [alr_pkg::POS_W-1:0]          main_x;
    logic [alr_pkg::POS_W-1:0]          main_y;
    logic [alr_pkg::LEVEL_W-1:0]        main_level;
    logic signed [alr_pkg::SIDE_W-1:0]  side_x;
    logic signed [alr_pkg::SIDE_W-1:0]  side_y;
    logic [alr_pkg::LEVEL_W-1:0]        side_level;
    logic                               side_valid;
    logic                               last;
  } pixel_t;

  pixel_t                    pixel_queue[$];
  logic [alr_pkg::POS_W-1:0] pen_x;
  logic [alr_pkg::POS_W-1:0] pen_y;

  function automatic logic [alr_pkg::LEVEL_W-1:0] gray_of(longint unsigned err);
    longint unsigned scaled;
    scaled = (err * 255) >> FRAC;
    return (scaled > 255) ? 8'd255 : scaled[alr_pkg::LEVEL_W-1:0];
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    // Keep the log short on a badly broken build; the count stays exact.
    if (mismatches_o < 50)
      $display("[%0t] pixel %0d: %s is %0d, expected %0d", $time, checked_o, what, got, want);
    mismatches_o++;
  endtask

  // Queue the pixel stream of one command and move the pen to its target.
  task automatic rasterize_command(alr_pkg::opcode_e op, logic [alr_pkg::POS_W-1:0] tx_in,
                                   logic [alr_pkg::POS_W-1:0] ty_in);
    int                   tx, ty, x0, y0, dx, dy, adx, ady;
    int                   cx, cy, span, side_dx, side_dy, minor_step, lo, hi;
    bit                   walk_x, rising;
    alr_pkg::slope_case_e kind;
    longint unsigned      err, inc;
    pixel_t               px;
    tx = tx_in;
    ty = ty_in;
    x0 = pen_x;
    y0 = pen_y;
    pen_x = tx_in;
    pen_y = ty_in;
    if (op == alr_pkg::OP_MOVE) return;

    dx  = tx - x0;
    dy  = ty - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;

    if (dx == 0) begin
      // Vertical or zero-length: walk y upward, no side pixel, endpoint dropped.
      cases_seen_o[alr_pkg::CASE_VERT] = 1'b1;
      lo = (y0 < ty) ? y0 : ty;
      hi = (y0 < ty) ? ty : y0;
      for (int y = lo; y < hi; y++) begin
        px        = '0;
        px.main_x = x0[alr_pkg::POS_W-1:0];
        px.main_y = y[alr_pkg::POS_W-1:0];
        px.last   = (y + 1 == hi);
        pixel_queue.push_back(px);
      end
      return;
    end

    rising = (dy == 0) || ((dx > 0) == (dy > 0));
    if (rising && ady <= adx) begin
      kind = alr_pkg::CASE_SHALLOW_POS;
      walk_x = 1; side_dx = 0; side_dy = 1;  minor_step = 1;
    end else if (rising) begin
      kind = alr_pkg::CASE_STEEP_POS;
      walk_x = 0; side_dx = 1; side_dy = 0;  minor_step = 1;
    end else if (ady <= adx) begin
      kind = alr_pkg::CASE_SHALLOW_NEG;
      walk_x = 1; side_dx = 0; side_dy = -1; minor_step = -1;
    end else begin
      kind = alr_pkg::CASE_STEEP_NEG;
      walk_x = 0; side_dx = 1; side_dy = 0;  minor_step = 1;
    end
    cases_seen_o[kind] = 1'b1;

    // Pick the starting end: left for x-major, lower for steep rising, upper for steep falling.
    if (walk_x) begin
      if (x0 <= tx) begin cx = x0; cy = y0; end else begin cx = tx; cy = ty; end
      span = adx;
      inc  = (longint'(ady) << FRAC) / span;
    end else if (kind == alr_pkg::CASE_STEEP_POS) begin
      if (y0 <= ty) begin cx = x0; cy = y0; end else begin cx = tx; cy = ty; end
      span = ady;
      inc  = (longint'(adx) << FRAC) / span;
    end else begin
      if (y0 >= ty) begin cx = x0; cy = y0; end else begin cx = tx; cy = ty; end
      span = ady;
      inc  = (longint'(adx) << FRAC) / span;
    end
    err = inc;

    for (int i = 0; i < span; i++) begin
      px            = '0;
      px.main_x     = cx[alr_pkg::POS_W-1:0];
      px.main_y     = cy[alr_pkg::POS_W-1:0];
      px.main_level = gray_of(err);
      px.side_x     = 8'(cx + side_dx);
      px.side_y     = 8'(cy + side_dy);
      px.side_level = (err >= ONE_Q) ? '0 : gray_of(ONE_Q - err);
      px.side_valid = 1'b1;
      px.last       = (i + 1 == span);
      pixel_queue.push_back(px);
      err = err + inc;
      if (walk_x) begin
        cx++;
        if (err >= ONE_Q) begin cy += minor_step; err -= ONE_Q; end
      end else begin
        cy += (kind == alr_pkg::CASE_STEEP_POS) ? 1 : -1;
        if (err >= ONE_Q) begin cx++; err -= ONE_Q; end
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    checked_o++;
    if (pixel_queue.size() == 0) begin
      flag_mismatch("unexpected pixel, main_x", main_x_o, -1);
      return;
    end
    want = pixel_queue.pop_front();
    if (main_x_o !== want.main_x) flag_mismatch("main_x", main_x_o, want.main_x);
    if (main_y_o !== want.main_y) flag_mismatch("main_y", main_y_o, want.main_y);
    if (main_level_o !== want.main_level)
      flag_mismatch("main_level", main_level_o, want.main_level);
    if (side_x_o !== want.side_x) flag_mismatch("side_x", $signed(side_x_o), want.side_x);
    if (side_y_o !== want.side_y) flag_mismatch("side_y", $signed(side_y_o), want.side_y);
    if (side_level_o !== want.side_level)
      flag_mismatch("side_level", side_level_o, want.side_level);
    if (side_valid_o !== want.side_valid)
      flag_mismatch("side_valid", side_valid_o, want.side_valid);
    if (last_o !== want.last) flag_mismatch("last", last_o, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x        = '0;
      pen_y        = '0;
      pixel_queue.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      commands_o   = 0;
      cases_seen_o = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        commands_o++;
        rasterize_command(alr_pkg::opcode_e'(opcode_i), pos_x_i, pos_y_i);
      end
      if (out_valid_o && !out_stall_i) check_pixel();
      pending_o = pixel_queue.size();
    end
  end

endmodule

### tb/tb_antialiased_line_rasterizer.sv
`timescale 1ns / 1ps
// Testbench top for antialiased_line_rasterizer: clock, reset, pen command stimulus
// and verdict. Depends on alr_pkg, the rasterizer RTL and alr_pixel_checker.
module tb_antialiased_line_rasterizer;

  localparam int COORD_MAX       = (1 << alr_pkg::POS_W) - 1;
  localparam int HOLD_OFF_CYCLES = 400;
  // Slowest correct run: ~210 lines of 63 pixels, each pixel waiting out a 75% stall,
  // plus setup/divide per line and the hold-off; the limit allows several times over.
  localparam int CYCLE_LIMIT     = 600_000;
  // Covers the longest line (N up to 63) with its setup, divide and load, plus margin.
  localparam int SETTLE_CYCLES   = COORD_MAX + alr_pkg::FRAC_BITS_DEF + 20;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic                        opcode_i     = 1'b0;
  logic [alr_pkg::POS_W-1:0]   pos_x_i      = '0;
  logic [alr_pkg::POS_W-1:0]   pos_y_i      = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [alr_pkg::POS_W-1:0]   main_x_o;
  logic [alr_pkg::POS_W-1:0]   main_y_o;
  logic [alr_pkg::LEVEL_W-1:0] main_level_o;
  logic [alr_pkg::SIDE_W-1:0]  side_x_o;
  logic [alr_pkg::SIDE_W-1:0]  side_y_o;
  logic [alr_pkg::LEVEL_W-1:0] side_level_o;
  logic                        side_valid_o;
  logic                        last_o;

  int         mismatch_count;
  int         pixels_pending;
  int         pixels_checked;
  int         commands_seen;
  logic [4:0] cases_seen;

  // Idle/stall odds in percent per cycle; changed only at a rising edge.
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_off      = 1'b0;
  int   cycle_count   = 0;

  // Stimulus-side copy of where the pen should be, used to aim short lines.
  int   aim_x = 0;
  int   aim_y = 0;

  antialiased_line_rasterizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .main_x_o     (main_x_o),
    .main_y_o     (main_y_o),
    .main_level_o (main_level_o),
    .side_x_o     (side_x_o),
    .side_y_o     (side_y_o),
    .side_level_o (side_level_o),
    .side_valid_o (side_valid_o),
    .last_o       (last_o)
  );

  alr_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .main_x_o     (main_x_o),
    .main_y_o     (main_y_o),
    .main_level_o (main_level_o),
    .side_x_o     (side_x_o),
    .side_y_o     (side_y_o),
    .side_level_o (side_level_o),
    .side_valid_o (side_valid_o),
    .last_o       (last_o),
    .mismatches_o (mismatch_count),
    .pending_o    (pixels_pending),
    .checked_o    (pixels_checked),
    .commands_o   (commands_seen),
    .cases_seen_o (cases_seen)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: stall at random, or hold off entirely while the pressure window is open.
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels still pending",
               cycle_count, pixels_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one command transaction; enter and leave at a falling edge. Valid stays
  // high after acceptance so back-to-back commands need no extra drive.
  task automatic send_command(alr_pkg::opcode_e op, int x, int y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i   = op;
    pos_x_i    = x[alr_pkg::POS_W-1:0];
    pos_y_i    = y[alr_pkg::POS_W-1:0];
    aim_x      = x;
    aim_y      = y;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every predicted pixel has come out.
  task automatic drain_pixels();
    in_valid_i = 1'b0;
    while (pixels_pending != 0) @(negedge clk_i);
  endtask

  // Switch idle/stall odds at a rising edge so the receiver never races the change.
  task automatic set_idling(int send_pct, int recv_pct);
    in_valid_i = 1'b0;
    @(posedge clk_i);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    @(negedge clk_i);
  endtask

  // Favor the grid edges now and then so the side pixel falls off the grid.
  function automatic int pick_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 0;
    if (roll < 16) return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic int nudge(int c);
    int v;
    v = c + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Mostly lines from wherever the pen sits: short ones hit vertical, single-step and
  // zero-length cases often; long ones sweep all slopes. Moves reposition the pen.
  task automatic send_random_command();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20)
      send_command(alr_pkg::OP_MOVE, pick_coord(), pick_coord());
    else if (roll < 50)
      send_command(alr_pkg::OP_LINE, nudge(aim_x), nudge(aim_y));
    else
      send_command(alr_pkg::OP_LINE, pick_coord(), pick_coord());
  endtask

  task automatic run_random_phase(int count, int send_pct, int recv_pct);
    set_idling(send_pct, recv_pct);
    repeat (count) send_random_command();
    drain_pixels();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed commands, no idling on either side.
    send_command(alr_pkg::OP_LINE, 0, 0);                  // line to the pen itself
    send_command(alr_pkg::OP_LINE, COORD_MAX, 0);          // horizontal, full width
    send_command(alr_pkg::OP_LINE, COORD_MAX, COORD_MAX);  // vertical upward, full height
    send_command(alr_pkg::OP_LINE, 0, 0);                  // slope +1, drawn from far end
    send_command(alr_pkg::OP_MOVE, 0, COORD_MAX);
    send_command(alr_pkg::OP_LINE, COORD_MAX, 0);          // slope exactly -1
    send_command(alr_pkg::OP_MOVE, 0, 1);
    send_command(alr_pkg::OP_LINE, COORD_MAX, 0);          // shallow falling: side y -1
    send_command(alr_pkg::OP_LINE, 0, 1);                  // same line, reversed
    send_command(alr_pkg::OP_MOVE, 0, COORD_MAX - 1);
    send_command(alr_pkg::OP_LINE, COORD_MAX, COORD_MAX);  // shallow rising: side y 63
    send_command(alr_pkg::OP_MOVE, COORD_MAX - 1, 0);
    send_command(alr_pkg::OP_LINE, COORD_MAX, COORD_MAX);  // steep rising: side x 63
    send_command(alr_pkg::OP_LINE, COORD_MAX - 1, 0);      // steep rising, reversed
    send_command(alr_pkg::OP_MOVE, 0, COORD_MAX);
    send_command(alr_pkg::OP_LINE, 1, 0);                  // steep falling from the top
    send_command(alr_pkg::OP_LINE, 0, COORD_MAX);          // steep falling, reversed
    send_command(alr_pkg::OP_MOVE, 5, 40);
    send_command(alr_pkg::OP_LINE, 5, 3);                  // vertical, from the lower end
    send_command(alr_pkg::OP_MOVE, 10, 10);
    send_command(alr_pkg::OP_LINE, 11, 10);                // single horizontal step
    send_command(alr_pkg::OP_LINE, 11, 11);                // single vertical step
    send_command(alr_pkg::OP_MOVE, 20, 20);
    send_command(alr_pkg::OP_LINE, 20, 20);                // zero-length after a move
    drain_pixels();

    // No idling, with a long output hold-off so the block backs up into its input.
    set_idling(0, 0);
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (50) send_random_command();
    join
    drain_pixels();

    run_random_phase(45, 75, 0);
    run_random_phase(45, 0, 75);
    run_random_phase(45, 14, 14);

    // Let any stray pixel surface before the verdict.
    set_idling(0, 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Run covered %0d commands and %0d pixels under idle, stall and hold-off phases",
             commands_seen, pixels_checked);
    $display("Slope cases hit (steep-, shallow-, shallow+, steep+, vertical): %b", cases_seen);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
